/* src/button_tap_hold_classifier_top_macros.svh */
// Assertion macros for the button tap/hold classifier.
// Included by the top level; depends on nothing else.
`ifndef BUTTON_TAP_HOLD_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_TAP_HOLD_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BTHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BTHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/bthc_pkg.sv */
// Shared types and constants for the button tap/hold classifier.
// Used by bthc_core and button_tap_hold_classifier_top; no dependencies.
package bthc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_W-1:0] HOLD_RESET    = 16'd100;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd40;

    localparam logic [1:0] TAPS_FOR_TRIPLE = 2'd3;

    typedef enum logic [1:0] {
        GEST_SINGLE = 2'd0,
        GEST_DOUBLE = 2'd1,
        GEST_TRIPLE = 2'd2,
        GEST_HOLD   = 2'd3
    } gesture_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD    = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] hold_ticks;
        logic [CFG_W-1:0] tap_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic     valid;
        gesture_t gesture;
    } result_t;

endpackage

/* src/bthc_core.sv */
// Classifier state and next-state logic: press/gap timers and tap count.
// Depends on bthc_pkg.
module bthc_core #(
    parameter int TIMER_BITS = bthc_pkg::TIMER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             down,
    input  bthc_pkg::cfg_t   cfg,
    output bthc_pkg::result_t res
);
    import bthc_pkg::*;

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic                  pressed_reg, pressed_next;
    logic [TIMER_BITS-1:0] press_reg,   press_next;
    logic [TIMER_BITS-1:0] gap_reg,     gap_next;
    logic [1:0]            taps_reg,    taps_next;

    logic [TIMER_BITS-1:0] press_inc;
    logic [TIMER_BITS-1:0] gap_inc;
    logic [1:0]            taps_inc;

    // Saturating timer increments and a plain tap-count increment
    assign press_inc = (press_reg == TMAX) ? press_reg : press_reg + 1'b1;
    assign gap_inc   = (gap_reg == TMAX) ? gap_reg : gap_reg + 1'b1;
    assign taps_inc  = taps_reg + 2'd1;

    // Advance state for one sample tick
    always_comb
    begin
        pressed_next = pressed_reg;
        press_next   = press_reg;
        gap_next     = gap_reg;
        taps_next    = taps_reg;
        res          = '0;
        if (step)
        begin
            if (down)
            begin
                pressed_next = 1'b1;
                press_next   = pressed_reg ? press_inc : TIMER_BITS'(1);
            end
            else if (pressed_reg)
            begin
                // release tick: classify the press
                pressed_next = 1'b0;
                gap_next     = '0;
                if (CW'(press_reg) >= CW'(cfg.hold_ticks))
                begin
                    taps_next   = '0;
                    res.valid   = 1'b1;
                    res.gesture = GEST_HOLD;
                end
                else if (taps_inc == TAPS_FOR_TRIPLE)
                begin
                    taps_next   = '0;
                    res.valid   = 1'b1;
                    res.gesture = GEST_TRIPLE;
                end
                else
                begin
                    taps_next = taps_inc;
                end
            end
            else
            begin
                // released: run gap timer, resolve pending taps on timeout
                gap_next = gap_inc;
                if (taps_reg != 2'd0 && CW'(gap_inc) > CW'(cfg.tap_timeout_ticks))
                begin
                    taps_next = '0;
                    res.valid = 1'b1;
                    case (taps_reg)
                        2'd1:    res.gesture = GEST_SINGLE;
                        2'd2:    res.gesture = GEST_DOUBLE;
                        default: res.gesture = GEST_TRIPLE;
                    endcase
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            press_reg   <= '0;
            gap_reg     <= '0;
            taps_reg    <= '0;
        end
        else
        begin
            pressed_reg <= pressed_next;
            press_reg   <= press_next;
            gap_reg     <= gap_next;
            taps_reg    <= taps_next;
        end
    end

endmodule

/* src/button_tap_hold_classifier_top.sv */
// Top level of the button tap/hold classifier: input register, config
// registers, output register. Depends on bthc_pkg, bthc_core and the macro header.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------
//  in      | in_valid  | in_stall  | button_down (1 bit)
//  out     | out_valid | out_stall | gesture (2 bits)
//  cfg     | cfg_we    | -         | cfg_index, cfg_data (16 bits)
//
// One sample per cycle sustained while out_stall is low; a gesture passes
// from its sample through the input register, then the output register.
// Reset clears timers, tap count and both stage valids; config returns
// to hold 100 and timeout 40. A stalled result holds the output register;
// one more sample waits in the input register, then in_stall rises.
module button_tap_hold_classifier_top #(
    parameter int TIMER_BITS = bthc_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            button_down,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      gesture,
    input  logic                            cfg_we,
    input  logic [bthc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bthc_pkg::CFG_W-1:0]      cfg_data
);
    import bthc_pkg::*;

    logic     in_vld_reg, in_vld_next;
    logic     in_down_reg;
    logic     out_vld_reg, out_vld_next;
    gesture_t gest_reg;
    cfg_t     cfg_reg, cfg_next;
    logic     out_free;
    logic     step;
    logic     in_accept;
    result_t  res;

    assign out_free  = !out_vld_reg || !out_stall;
    assign step      = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_vld_reg;
    assign gesture   = gest_reg;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HOLD:    cfg_next.hold_ticks        = cfg_data;
                CFG_TIMEOUT: cfg_next.tap_timeout_ticks = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // Stage valids
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (step)
            out_vld_next = res.valid;
        else if (!out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= '{hold_ticks: HOLD_RESET, tap_timeout_ticks: TIMEOUT_RESET};
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            cfg_reg     <= cfg_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_down_reg <= button_down;
        if (step)
            gest_reg <= res.gesture;
    end

    bthc_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .down  (in_down_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

`include "button_tap_hold_classifier_top_macros.svh"

    // A held sample is never dropped
    `BTHC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_reg && !out_free, in_vld_reg)
    // A gesture is only produced when a sample advances
    `BTHC_ASSERT_NOW(a_res_step, clk, rst_n, res.valid, step)
    // Stall is only raised with a sample waiting
    `BTHC_ASSERT_NOW(a_stall_vld, clk, rst_n, in_stall, in_vld_reg && out_vld_reg)

endmodule
